// File: design/nnue_pkg.sv
// shared constants and helpers for the two-layer network evaluator
package nnue_pkg;
    localparam int LANE_COUNT   = 16;
    localparam int WORD_W       = 16;
    localparam int ADDR_W       = 9;
    localparam int HIDDEN_MAX   = 16;
    localparam int DEF_HIDDEN   = 16;
    localparam int BIAS_BASE    = 256;
    localparam int OUTW_BASE    = 272;
    localparam int STORE_END    = 288;
    localparam int CLIP_LIMIT   = 127;
    localparam int ROUND_HALF   = 16;
    localparam int SCALE_SHIFT  = 5;
    localparam int TOTAL_W      = 22;

    localparam logic MODE_EVAL = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // clip a signed word to +/-127
    function automatic logic signed [WORD_W-1:0] clip_word(input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        begin
            r = v;
            if (v < -WORD_W'(CLIP_LIMIT))
                r = -WORD_W'(CLIP_LIMIT);
            else if (v > WORD_W'(CLIP_LIMIT))
                r = WORD_W'(CLIP_LIMIT);
            return r;
        end
    endfunction
endpackage

// File: design/nnue_cell.sv
// one hidden node: weights, bias, output weight, and a wrapping multiply-accumulate
module nnue_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [3:0]                        wr_lane,
    input  logic                              wr_bias,
    input  logic                              wr_outw,
    input  logic signed [nnue_pkg::WORD_W-1:0] wr_value,
    input  logic                              start,
    input  logic                              step,
    input  logic [3:0]                        lane_idx,
    input  logic signed [nnue_pkg::WORD_W-1:0] lane_x,
    input  logic                              finish,
    input  logic signed [nnue_pkg::TOTAL_W-1:0] sum_in,
    output logic signed [nnue_pkg::TOTAL_W-1:0] sum_out
);
    logic [nnue_pkg::WORD_W-1:0] weight_mem [nnue_pkg::LANE_COUNT];
    logic [nnue_pkg::WORD_W-1:0] bias_reg;
    logic [nnue_pkg::WORD_W-1:0] outw_reg;
    logic [nnue_pkg::WORD_W-1:0] acc_reg;
    logic [nnue_pkg::WORD_W-1:0] acc_next;
    logic signed [nnue_pkg::TOTAL_W-1:0] sum_reg;
    logic signed [nnue_pkg::TOTAL_W-1:0] sum_next;
    logic signed [nnue_pkg::WORD_W-1:0] hid;
    logic [2*nnue_pkg::WORD_W-1:0] prod;
    logic [2*nnue_pkg::WORD_W-1:0] oprod;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            weight_mem[wr_lane] <= wr_value;
        if (wr_bias)
            bias_reg <= wr_value;
        if (wr_outw)
            outw_reg <= wr_value;
    end

    always_comb
    begin
        prod     = weight_mem[lane_idx] * {{nnue_pkg::WORD_W{1'b0}}, lane_x};
        acc_next = acc_reg;
        if (start)
            acc_next = bias_reg;
        else if (step)
            acc_next = acc_reg + prod[nnue_pkg::WORD_W-1:0];
        hid   = nnue_pkg::clip_word(acc_reg);
        oprod = hid * outw_reg;
        // sum passes down the row; each cell adds its output product
        sum_next = sum_in + nnue_pkg::TOTAL_W'($signed(oprod[nnue_pkg::WORD_W-1:0]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (finish)
                sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;
endmodule

// File: design/nnue_two_layer_eval.sv
// top level of the two-layer network evaluator
// usage:
//  input channel in_valid/in_stall carries mode, weight_addr, weight_value and
//  the four lane groups. a load transaction writes one weight word.
//  an evaluate transaction clips the 16 lanes, then a row of HIDDEN_NODES cells
//  accumulates one input lane per cycle, then the output sum ripples down the
//  cell row one cell per cycle and is rounded into the result register.
//  one evaluation at a time: the block takes no new transaction until the
//  lane loop and the sum chain through the cells are done and the score is
//  loaded into the result register.
//  output channel out_valid/out_stall carries score; a stalled result holds in
//  its register while the block keeps taking transactions, and a following
//  evaluation waits at the end of the sum chain until the register frees.
//  output_bias is written with cfg_we/cfg_data. reset clears control and the
//  bias; weight words are undefined until loaded.
module nnue_two_layer_eval
#(
    parameter int HIDDEN_NODES = nnue_pkg::DEF_HIDDEN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [8:0]  weight_addr,
    input  logic [15:0] weight_value,
    input  logic [63:0] lanes_0_3,
    input  logic [63:0] lanes_4_7,
    input  logic [63:0] lanes_8_11,
    input  logic [63:0] lanes_12_15,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] score
);
    localparam int W = nnue_pkg::WORD_W;
    localparam int TW = nnue_pkg::TOTAL_W;
    localparam int CW = $clog2(HIDDEN_NODES + 1);

    typedef enum logic [2:0] {S_IDLE, S_START, S_MAC, S_LAST, S_CHAIN} state_t;

    state_t state_reg;
    logic [3:0] lane_reg;
    logic [CW-1:0] chain_reg;
    logic signed [W-1:0] x_reg [nnue_pkg::LANE_COUNT];
    logic [15:0] bias_reg;
    logic [15:0] score_reg;
    logic out_valid_reg;
    logic score_load;
    logic [255:0] lanes_all;
    logic in_acc;
    logic signed [TW-1:0] chain [HIDDEN_NODES+1];
    logic signed [TW-1:0] total;
    logic signed [TW-1:0] rounded;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign lanes_all = {lanes_12_15, lanes_8_11, lanes_4_7, lanes_0_3};
    assign chain[0]  = TW'($signed(bias_reg));
    // chain done and the result register is free or being drained
    assign score_load = state_reg == S_CHAIN && chain_reg == CW'(HIDDEN_NODES)
        && (!out_valid_reg || !out_stall);

    genvar g;
    generate
        for (g = 0; g < HIDDEN_NODES; g++)
        begin : g_cell
            logic hit_w, hit_b, hit_o;
            assign hit_w = in_acc && mode == nnue_pkg::MODE_LOAD
                && weight_addr < 9'(nnue_pkg::BIAS_BASE) && weight_addr[3:0] == 4'(g);
            assign hit_b = in_acc && mode == nnue_pkg::MODE_LOAD
                && weight_addr == 9'(nnue_pkg::BIAS_BASE + g);
            assign hit_o = in_acc && mode == nnue_pkg::MODE_LOAD
                && weight_addr == 9'(nnue_pkg::OUTW_BASE + g);
            nnue_cell u_cell (
                .clk(clk), .rst_n(rst_n),
                .wr_en(hit_w), .wr_lane(weight_addr[7:4]),
                .wr_bias(hit_b), .wr_outw(hit_o), .wr_value(weight_value),
                .start(state_reg == S_START),
                .step(state_reg == S_MAC || state_reg == S_LAST),
                .lane_idx(lane_reg), .lane_x(x_reg[lane_reg]),
                .finish(state_reg == S_CHAIN && chain_reg == CW'(g)),
                .sum_in(chain[g]), .sum_out(chain[g+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (in_acc && mode == nnue_pkg::MODE_EVAL)
            for (int k = 0; k < nnue_pkg::LANE_COUNT; k++)
                x_reg[k] <= nnue_pkg::clip_word(lanes_all[16*k +: 16]);
    end

    always_comb
    begin
        total   = chain[HIDDEN_NODES];
        rounded = (total >= 0) ? total + TW'(nnue_pkg::ROUND_HALF)
                               : total - TW'(nnue_pkg::ROUND_HALF);
        // truncate toward zero
        if (rounded < 0)
            rounded = -((-rounded) >>> nnue_pkg::SCALE_SHIFT);
        else
            rounded = rounded >>> nnue_pkg::SCALE_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_reg      <= '0;
            chain_reg     <= '0;
            bias_reg      <= '0;
            score_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                bias_reg <= cfg_data;
            if (score_load)
            begin
                score_reg     <= rounded[15:0];
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_acc && mode == nnue_pkg::MODE_EVAL)
                        state_reg <= S_START;
                S_START:
                begin
                    lane_reg  <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    lane_reg <= lane_reg + 4'd1;
                    if (lane_reg == 4'(nnue_pkg::LANE_COUNT - 2))
                        state_reg <= S_LAST;
                end
                S_LAST:
                begin
                    chain_reg <= '0;
                    state_reg <= S_CHAIN;
                end
                S_CHAIN:
                begin
                    if (chain_reg != CW'(HIDDEN_NODES))
                        chain_reg <= chain_reg + 1'b1;
                    else if (score_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC |-> in_stall)
        else $error("accepted during evaluation");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(score))
        else $error("result dropped while stalled");
    a_chain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHAIN && chain_reg == CW'(HIDDEN_NODES) |=> out_valid)
        else $error("sum chain did not finish");
endmodule

// File: sim/testbench.sv
// testbench for nnue_two_layer_eval: queued random and directed traffic against a score predictor
`timescale 1ns / 1ps

module testbench;
    localparam int NODES      = nnue_pkg::DEF_HIDDEN;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 60;
    localparam int CYCLE_MAX  = 600000;

    typedef struct packed {
        logic               mode;
        logic [8:0]         addr;
        logic [15:0]        wval;
        logic [3:0][63:0]   grp;
    } net_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = nnue_pkg::MODE_EVAL;
    logic [8:0]  weight_addr = '0;
    logic [15:0] weight_value = '0;
    logic [63:0] lanes_0_3 = '0;
    logic [63:0] lanes_4_7 = '0;
    logic [63:0] lanes_8_11 = '0;
    logic [63:0] lanes_12_15 = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] score;

    nnue_two_layer_eval uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .weight_addr(weight_addr), .weight_value(weight_value),
        .lanes_0_3(lanes_0_3), .lanes_4_7(lanes_4_7), .lanes_8_11(lanes_8_11),
        .lanes_12_15(lanes_12_15), .out_valid(out_valid), .out_stall(out_stall),
        .score(score)
    );

    always #10 clk = ~clk;

    net_item_t   pending_items[$];
    logic [15:0] expected_scores[$];
    int          mismatches = 0;
    int          scores_seen = 0;
    int          cycle_count = 0;

    // predictor copy of the weight store and bias
    logic [15:0] hid_w [256];
    logic [15:0] hid_b [16];
    logic [15:0] out_w [16];
    logic [15:0] bias_reg = '0;

    function automatic int sx16(logic [15:0] v);
        return int'(signed'(v));
    endfunction

    function automatic int clip127(int v);
        if (v < -nnue_pkg::CLIP_LIMIT) return -nnue_pkg::CLIP_LIMIT;
        if (v > nnue_pkg::CLIP_LIMIT) return nnue_pkg::CLIP_LIMIT;
        return v;
    endfunction

    function automatic logic [15:0] predict_score(logic [3:0][63:0] grp);
        logic [15:0] x [16];
        logic [15:0] acc;
        logic [31:0] prod;
        int          total;
        int          h;
        for (int k = 0; k < nnue_pkg::LANE_COUNT; k++)
            x[k] = 16'(clip127(sx16(grp[k/4][16*(k%4) +: 16])));
        total = sx16(bias_reg);
        for (int n = 0; n < NODES; n++)
        begin
            acc = hid_b[n];
            for (int i = 0; i < nnue_pkg::LANE_COUNT; i++)
            begin
                prod = 32'(sx16(hid_w[i*16+n]) * sx16(x[i]));
                acc = acc + prod[15:0];
            end
            h = clip127(sx16(acc));
            prod = 32'(h * sx16(out_w[n]));
            total += sx16(prod[15:0]);
        end
        total += (total >= 0) ? nnue_pkg::ROUND_HALF : -nnue_pkg::ROUND_HALF;
        total = total / 32;
        return 16'(total);
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d", what, signed'(got), signed'(want));
        mismatches++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    int send_gap = 0;
    int send_calm = 0;
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (send_gap > 0 && send_calm == 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                net_item_t it;
                it = pending_items.pop_front();
                mode <= it.mode;
                weight_addr <= it.addr;
                weight_value <= it.wval;
                lanes_0_3 <= it.grp[0];
                lanes_4_7 <= it.grp[1];
                lanes_8_11 <= it.grp[2];
                lanes_12_15 <= it.grp[3];
                in_valid <= 1'b1;
                send_gap <= gap_len();
                // occasional stretch with no idling at all
                if (send_calm > 0) send_calm <= send_calm - 1;
                else if ($urandom_range(0, 99) == 0) send_calm <= 40;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off so the block backs up
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(posedge clk)
    begin
        if (!hold_done && scores_seen == 30)
        begin
            hold_done <= 1;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left <= gap_len();
            out_stall <= 1'b0;
        end
    end

    // monitor: predict on accepted inputs, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (mode == nnue_pkg::MODE_LOAD)
                begin
                    if (weight_addr < nnue_pkg::BIAS_BASE)
                        hid_w[weight_addr] = weight_value;
                    else if (weight_addr < nnue_pkg::OUTW_BASE)
                        hid_b[weight_addr - nnue_pkg::BIAS_BASE] = weight_value;
                    else if (weight_addr < nnue_pkg::STORE_END)
                        out_w[weight_addr - nnue_pkg::OUTW_BASE] = weight_value;
                end
                else
                begin
                    expected_scores.push_back(predict_score({lanes_12_15, lanes_8_11,
                                                             lanes_4_7, lanes_0_3}));
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_scores.size() == 0)
                    report_mismatch("unexpected score", score, 16'h0);
                else
                    begin
                        logic [15:0] want;
                        want = expected_scores.pop_front();
                        if (score !== want) report_mismatch("score", score, want);
                    end
                scores_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_MAX)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("nnue_two_layer_eval verification failed");
            $finish;
        end
    end

    function automatic logic [15:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 16'($urandom_range(0, 16) - 8);
        if (r < 6) return 16'($urandom_range(0, 400) - 200);
        if (r == 6) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        return 16'($urandom);
    endfunction

    function automatic net_item_t load_item(int addr, logic [15:0] v);
        net_item_t it;
        it.mode = nnue_pkg::MODE_LOAD;
        it.addr = 9'(addr);
        it.wval = v;
        // lanes carry junk that must be ignored
        for (int g = 0; g < 4; g++) it.grp[g] = {$urandom, $urandom};
        return it;
    endfunction

    function automatic net_item_t eval_lanes(logic [15:0] lane_word, bit rand_lanes);
        net_item_t it;
        int r;
        it.mode = nnue_pkg::MODE_EVAL;
        it.addr = 9'($urandom);
        it.wval = 16'($urandom);
        for (int k = 0; k < nnue_pkg::LANE_COUNT; k++)
        begin
            r = $urandom_range(0, 3);
            if (!rand_lanes) it.grp[k/4][16*(k%4) +: 16] = lane_word;
            else if (r == 0) it.grp[k/4][16*(k%4) +: 16] = 16'($urandom);
            else it.grp[k/4][16*(k%4) +: 16] = 16'($urandom_range(0, 320) - 160);
        end
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_scores.size() > 0)
            @(posedge clk);
        // a trailing load leaves no result to wait on
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_bias(logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        bias_reg = v;
    endtask

    initial
    begin
        logic [15:0] bias_list [5];
        logic [15:0] corner [8];
        int a;
        bias_list = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000};
        bias_list[3] = rand_word();
        bias_list[4] = 16'($urandom);
        corner = '{16'h7FFF, 16'h8000, 16'h007F, 16'hFF81, 16'h0080, 16'hFF80,
                   16'h0000, 16'h0001};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 5; ph++)
        begin
            write_bias(bias_list[ph]);
            // every store word is written before any evaluate reads it
            if (ph == 0)
                for (int w = 0; w < nnue_pkg::STORE_END; w++)
                    pending_items.push_back(load_item(w, 16'($urandom_range(0, 6) - 3)));
            if (ph == 1)
            begin
                // extreme weights on the first and last nodes, extreme lanes, out-of-range loads
                pending_items.push_back(load_item(0, 16'h7FFF));
                pending_items.push_back(load_item(nnue_pkg::BIAS_BASE, 16'h8000));
                pending_items.push_back(load_item(nnue_pkg::OUTW_BASE, 16'h7FFF));
                pending_items.push_back(load_item(nnue_pkg::STORE_END, 16'h1234));
                pending_items.push_back(load_item(511, 16'hFFFF));
                foreach (corner[c]) pending_items.push_back(eval_lanes(corner[c], 0));
                pending_items.push_back(load_item(nnue_pkg::OUTW_BASE + 15, 16'h8000));
                pending_items.push_back(load_item(255, 16'h8000));
                foreach (corner[c]) pending_items.push_back(eval_lanes(corner[c], 0));
            end
            for (int n = 0; n < 90; n++)
            begin
                if ($urandom_range(0, 99) < 70)
                begin
                    pending_items.push_back(eval_lanes(16'h0, 1));
                end
                else
                begin
                    a = ($urandom_range(0, 9) == 0)
                        ? $urandom_range(nnue_pkg::STORE_END, 511)
                        : $urandom_range(0, nnue_pkg::STORE_END - 1);
                    pending_items.push_back(load_item(a, rand_word()));
                end
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("nnue_two_layer_eval verification clean");
        else
            $display("nnue_two_layer_eval verification failed");
        $finish;
    end
endmodule

// File: sim.f
design/nnue_pkg.sv
design/nnue_cell.sv
design/nnue_two_layer_eval.sv
sim/testbench.sv
